// ----- rtl/core/gso_pkg.sv -----
// Shared constants, types and state encodings for the Gram-Schmidt orthonormaliser.
package gso_pkg;

  localparam int NUM_VECTORS   = 4;
  localparam int VECTOR_LENGTH = 4;
  localparam int CAPACITY      = NUM_VECTORS * VECTOR_LENGTH;

  localparam int WORD_W   = 32;
  localparam int FRAC     = 28;
  localparam int IN_SHIFT = 12;
  localparam int OUT_W    = 16;
  localparam int THR_W    = 16;
  localparam int QUOT_W   = 30;
  localparam int SHIFT_W  = 5;

  localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int ROW_W  = $clog2(NUM_VECTORS + 1);
  localparam int K_W    = $clog2(VECTOR_LENGTH + 1);
  localparam int KI_W   = (VECTOR_LENGTH > 1) ? $clog2(VECTOR_LENGTH) : 1;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    word_t             data;
  } ram_wr_t;

  typedef enum logic [4:0] {
    S_IDLE, S_ZERO, S_RD, S_SQ, S_NZ, S_SQRT, S_DIV, S_DIVW, S_WR,
    S_DOT, S_RND, S_SUB, S_CK, S_CSQ, S_CM1, S_CM2, S_CM3, S_OUT
  } back_state_t;

  typedef enum logic [1:0] {
    PH_NORM1, PH_PROJ, PH_CLEAN, PH_FINAL
  } phase_t;

  typedef enum logic [1:0] {
    SQ_IDLE, SQ_NORM, SQ_ITER
  } sqrt_state_t;

  typedef enum logic {
    DV_IDLE, DV_ITER
  } div_state_t;

endpackage

// ----- rtl/core/gso_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module gso_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/gso_front.sv -----
// Front end: takes elements into the store and queues one run command per set.
module gso_front import gso_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [OUT_W-1:0]  in_element,
  input  logic              in_last_in,
  input  logic              back_busy,
  output logic              cmd_valid,
  output logic [CNT_W-1:0]  cmd_count,
  input  logic              cmd_ready,
  output ram_wr_t           ram_wr
);

  logic [CNT_W-1:0] load_count_r, load_count_nxt;
  logic             cmd_valid_r, cmd_valid_nxt;
  logic [CNT_W-1:0] cmd_count_r, cmd_count_nxt;
  logic             accept;
  logic             room;
  logic [CNT_W-1:0] count_after;

  assign busy        = cmd_valid_r | back_busy;
  assign accept      = start & ~busy;
  assign room        = (load_count_r < CAPACITY);
  assign count_after = load_count_r + CNT_W'(room);
  assign cmd_valid   = cmd_valid_r;
  assign cmd_count   = cmd_count_r;

  always_comb begin
    ram_wr.en   = accept & room;
    ram_wr.addr = load_count_r[ADDR_W-1:0];
    ram_wr.data = {{(WORD_W-OUT_W-IN_SHIFT){in_element[OUT_W-1]}}, in_element,
                   {IN_SHIFT{1'b0}}};
  end

  always_comb begin
    load_count_nxt = load_count_r;
    cmd_valid_nxt  = cmd_valid_r;
    cmd_count_nxt  = cmd_count_r;
    if (cmd_valid_r && cmd_ready) begin
      cmd_valid_nxt = 1'b0;
    end
    if (accept) begin
      if (in_last_in) begin
        cmd_valid_nxt  = 1'b1;
        cmd_count_nxt  = count_after;
        load_count_nxt = '0;
      end else begin
        load_count_nxt = count_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_count_r <= '0;
      cmd_valid_r  <= 1'b0;
    end else begin
      load_count_r <= load_count_nxt;
      cmd_valid_r  <= cmd_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_count_r <= cmd_count_nxt;
  end

endmodule

// ----- rtl/core/gso_sqrt.sv -----
// Iterative integer square root with an even pre-shift, one step per cycle.
module gso_sqrt import gso_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [63:0]        radicand,
  output logic               done,
  output logic [31:0]        root,
  output logic [SHIFT_W-1:0] shift
);

  sqrt_state_t        st_r, st_nxt;
  logic [63:0]        rem_r, rem_nxt, res_r, res_nxt;
  logic [63:0]        bitv, trial;
  logic [4:0]         step_r, step_nxt;
  logic [SHIFT_W-1:0] h_r, h_nxt;
  logic               done_r, done_nxt;

  assign bitv  = 64'h4000_0000_0000_0000 >> {step_r, 1'b0};
  assign trial = res_r + bitv;
  assign done  = done_r;
  assign root  = res_r[31:0];
  assign shift = h_r;

  always_comb begin
    st_nxt   = st_r;
    rem_nxt  = rem_r;
    res_nxt  = res_r;
    step_nxt = step_r;
    h_nxt    = h_r;
    done_nxt = 1'b0;
    case (st_r)
      SQ_IDLE: begin
        if (start) begin
          rem_nxt = radicand;
          h_nxt   = '0;
          st_nxt  = SQ_NORM;
        end
      end
      SQ_NORM: begin
        if (rem_r < 64'h1000_0000_0000_0000) begin
          rem_nxt = rem_r << 2;
          h_nxt   = h_r + 1'b1;
        end else begin
          res_nxt  = '0;
          step_nxt = '0;
          st_nxt   = SQ_ITER;
        end
      end
      SQ_ITER: begin
        if (rem_r >= trial) begin
          rem_nxt = rem_r - trial;
          res_nxt = (res_r >> 1) + bitv;
        end else begin
          res_nxt = res_r >> 1;
        end
        step_nxt = step_r + 1'b1;
        if (step_r == 5'd31) begin
          done_nxt = 1'b1;
          st_nxt   = SQ_IDLE;
        end
      end
      default: st_nxt = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= SQ_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    res_r  <= res_nxt;
    step_r <= step_nxt;
    h_r    <= h_nxt;
  end

endmodule

// ----- rtl/core/gso_div.sv -----
// Restoring divider, one quotient bit per cycle.
module gso_div import gso_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [63:0]       num,
  input  logic [31:0]       den,
  output logic              done,
  output logic [QUOT_W-1:0] quot
);

  div_state_t        st_r, st_nxt;
  logic [63:0]       rem_r, rem_nxt, dsh_r, dsh_nxt;
  logic [QUOT_W-1:0] q_r, q_nxt;
  logic [4:0]        step_r, step_nxt;
  logic              done_r, done_nxt;

  assign done = done_r;
  assign quot = q_r;

  always_comb begin
    st_nxt   = st_r;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    step_nxt = step_r;
    done_nxt = 1'b0;
    case (st_r)
      DV_IDLE: begin
        if (start) begin
          rem_nxt  = num;
          dsh_nxt  = 64'(den) << (QUOT_W - 1);
          q_nxt    = '0;
          step_nxt = '0;
          st_nxt   = DV_ITER;
        end
      end
      DV_ITER: begin
        if (rem_r >= dsh_r) begin
          rem_nxt = rem_r - dsh_r;
          q_nxt   = {q_r[QUOT_W-2:0], 1'b1};
        end else begin
          q_nxt   = {q_r[QUOT_W-2:0], 1'b0};
        end
        dsh_nxt  = dsh_r >> 1;
        step_nxt = step_r + 1'b1;
        if (step_r == 5'(QUOT_W - 1)) begin
          done_nxt = 1'b1;
          st_nxt   = DV_IDLE;
        end
      end
      default: st_nxt = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= DV_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    dsh_r  <= dsh_nxt;
    q_r    <= q_nxt;
    step_r <= step_nxt;
  end

endmodule

// ----- rtl/core/gso_back.sv -----
// Back end: sequencer that runs modified Gram-Schmidt, cleanup and result emission.
module gso_back import gso_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cmd_valid,
  input  logic [CNT_W-1:0]        cmd_count,
  output logic                    cmd_ready,
  output logic                    back_busy,
  input  logic [THR_W-1:0]        zero_threshold,
  output ram_wr_t                 ram_wr,
  output logic [ADDR_W-1:0]       ram_raddr,
  input  word_t                   ram_rdata,
  output logic                    out_strobe,
  output logic signed [OUT_W-1:0] out_result_element,
  output logic                    out_degenerate,
  output logic                    out_last_out
);

  back_state_t      state_r, state_nxt;
  phase_t           phase_r, phase_nxt;
  logic [ROW_W-1:0] i_r, i_nxt, j_r, j_nxt, row_r, row_nxt;
  logic [K_W-1:0]   k_r, k_nxt;
  logic [KI_W-1:0]  kidx, pidx_r, pidx_nxt;
  logic             pend_r, pend_nxt, sneg_r, sneg_nxt;
  logic [CNT_W-1:0] p_r, p_nxt;
  word_t            vec_r [VECTOR_LENGTH];
  word_t            vec_nxt [VECTOR_LENGTH];
  word_t            u_r [VECTOR_LENGTH];
  word_t            u_nxt [VECTOR_LENGTH];
  logic [63:0]      n2_r, n2_nxt;
  logic signed [63:0] dot_r, dot_nxt;
  logic             c_neg_r, c_neg_nxt;
  logic [31:0]      c_mag_r, c_mag_nxt;
  logic [31:0]      root_r, root_nxt;
  logic [SHIFT_W-1:0] h_r, h_nxt;
  logic             degen_r, degen_nxt;
  logic [31:0]      mul_a, mul_b;
  logic [63:0]      prod_r;

  logic               sq_start, sq_done;
  logic [31:0]        sq_root;
  logic [SHIFT_W-1:0] sq_shift;
  logic               dv_start, dv_done;
  logic [63:0]        dv_num;
  logic [QUOT_W-1:0]  dv_quot;

  logic               ostb_r, ostb_nxt, odeg_r, odeg_nxt, olast_r, olast_nxt;
  logic signed [OUT_W-1:0] oelem_r, oelem_nxt;

  logic [31:0]      vmag, umag;
  logic [63:0]      scaled_mag, thr_lhs, dot_mag, c_round, sub_t;
  logic [QUOT_W-1:0] q_sat;
  logic [31:0]      o_round;
  logic [OUT_W-1:0] o_mag;
  logic [ADDR_W-1:0] row_addr;

  function automatic logic [31:0] mag_w(word_t x);
    return x[WORD_W-1] ? $unsigned(-x) : $unsigned(x);
  endfunction

  assign kidx       = k_r[KI_W-1:0];
  assign vmag       = mag_w(vec_r[kidx]);
  assign umag       = mag_w(u_r[kidx]);
  assign scaled_mag = 64'(vmag) << h_r;
  assign thr_lhs    = scaled_mag << 24;
  assign dv_num     = (scaled_mag << FRAC) + 64'(root_r >> 1);
  assign dot_mag    = dot_r[63] ? $unsigned(-dot_r) : $unsigned(dot_r);
  assign c_round    = (dot_mag + (64'd1 << (FRAC - 1))) >> FRAC;
  assign sub_t      = (prod_r + (64'd1 << (FRAC - 1))) >> FRAC;
  assign q_sat      = (dv_quot > (QUOT_W'(1) << FRAC)) ? (QUOT_W'(1) << FRAC) : dv_quot;
  assign o_round    = (vmag + 32'd8192) >> 14;
  assign o_mag      = (o_round > 32'd16384) ? OUT_W'(16384) : o_round[OUT_W-1:0];
  assign row_addr   = ADDR_W'(row_r * VECTOR_LENGTH) + ADDR_W'(kidx);

  assign cmd_ready  = (state_r == S_IDLE);
  assign back_busy  = (state_r != S_IDLE);
  assign ram_raddr  = row_addr;

  assign out_strobe         = ostb_r;
  assign out_result_element = oelem_r;
  assign out_degenerate     = odeg_r;
  assign out_last_out       = olast_r;

  gso_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (n2_r),
    .done     (sq_done),
    .root     (sq_root),
    .shift    (sq_shift)
  );

  gso_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dv_start),
    .num   (dv_num),
    .den   (root_r),
    .done  (dv_done),
    .quot  (dv_quot)
  );

  // Shared multiplier operands.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_SQ:  begin mul_a = vmag;                mul_b = vmag;   end
      S_DOT: begin mul_a = vmag;                mul_b = umag;   end
      S_SUB: begin mul_a = c_mag_r;             mul_b = umag;   end
      S_CM1: begin mul_a = 32'(zero_threshold); mul_b = root_r; end
      S_CM2: begin mul_a = vmag;                mul_b = vmag;   end
      default: begin mul_a = '0;                mul_b = '0;     end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    row_nxt   = row_r;
    k_nxt     = k_r;
    pidx_nxt  = pidx_r;
    pend_nxt  = pend_r;
    sneg_nxt  = sneg_r;
    p_nxt     = p_r;
    vec_nxt   = vec_r;
    u_nxt     = u_r;
    n2_nxt    = n2_r;
    dot_nxt   = dot_r;
    c_neg_nxt = c_neg_r;
    c_mag_nxt = c_mag_r;
    root_nxt  = root_r;
    h_nxt     = h_r;
    degen_nxt = degen_r;
    ostb_nxt  = 1'b0;
    oelem_nxt = oelem_r;
    odeg_nxt  = odeg_r;
    olast_nxt = olast_r;
    sq_start  = 1'b0;
    dv_start  = 1'b0;
    ram_wr.en   = 1'b0;
    ram_wr.addr = row_addr;
    ram_wr.data = vec_r[kidx];

    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          p_nxt     = cmd_count;
          state_nxt = S_ZERO;
        end
      end

      // Entries beyond the loaded count are cleared so later reads need no mask.
      S_ZERO: begin
        if (p_r < CAPACITY) begin
          ram_wr.en   = 1'b1;
          ram_wr.addr = p_r[ADDR_W-1:0];
          ram_wr.data = '0;
          p_nxt       = p_r + 1'b1;
        end else begin
          i_nxt     = '0;
          row_nxt   = '0;
          phase_nxt = PH_NORM1;
          k_nxt     = '0;
          pend_nxt  = 1'b0;
          state_nxt = S_RD;
        end
      end

      S_RD: begin
        if (pend_r) begin
          vec_nxt[pidx_r] = ram_rdata;
        end
        if (k_r < VECTOR_LENGTH) begin
          pend_nxt = 1'b1;
          pidx_nxt = kidx;
          k_nxt    = k_r + 1'b1;
        end else begin
          pend_nxt = 1'b0;
          k_nxt    = '0;
          if (phase_r == PH_PROJ) begin
            dot_nxt   = '0;
            state_nxt = S_DOT;
          end else begin
            n2_nxt    = '0;
            state_nxt = S_SQ;
          end
        end
      end

      S_SQ: begin
        if (pend_r) begin
          n2_nxt = n2_r + prod_r;
        end
        if (k_r < VECTOR_LENGTH) begin
          pend_nxt = 1'b1;
          k_nxt    = k_r + 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          k_nxt     = '0;
          state_nxt = S_NZ;
        end
      end

      S_NZ: begin
        k_nxt = '0;
        if (n2_r == 64'd0) begin
          if (phase_r == PH_NORM1) begin
            u_nxt     = vec_r;
            row_nxt   = i_r;
            state_nxt = S_WR;
          end else begin
            degen_nxt = 1'b1;
            state_nxt = S_OUT;
          end
        end else if (phase_r == PH_CLEAN) begin
          state_nxt = S_CK;
        end else begin
          sq_start  = 1'b1;
          state_nxt = S_SQRT;
        end
      end

      S_SQRT: begin
        if (sq_done) begin
          root_nxt  = sq_root;
          h_nxt     = sq_shift;
          state_nxt = S_DIV;
        end
      end

      S_DIV: begin
        if (k_r < VECTOR_LENGTH) begin
          dv_start  = 1'b1;
          state_nxt = S_DIVW;
        end else begin
          k_nxt = '0;
          if (phase_r == PH_NORM1) begin
            u_nxt     = vec_r;
            row_nxt   = i_r;
            state_nxt = S_WR;
          end else begin
            degen_nxt = 1'b0;
            state_nxt = S_OUT;
          end
        end
      end

      S_DIVW: begin
        if (dv_done) begin
          vec_nxt[kidx] = vec_r[kidx][WORD_W-1] ? -$signed({2'b00, q_sat})
                                                : $signed({2'b00, q_sat});
          k_nxt     = k_r + 1'b1;
          state_nxt = S_DIV;
        end
      end

      S_WR: begin
        if (k_r < VECTOR_LENGTH) begin
          ram_wr.en = 1'b1;
          k_nxt     = k_r + 1'b1;
        end else begin
          k_nxt    = '0;
          pend_nxt = 1'b0;
          state_nxt = S_RD;
          if (phase_r == PH_NORM1 && (i_r + 1'b1) < NUM_VECTORS) begin
            j_nxt     = ROW_W'(i_r + 1'b1);
            row_nxt   = ROW_W'(i_r + 1'b1);
            phase_nxt = PH_PROJ;
          end else if (phase_r == PH_PROJ && (j_r + 1'b1) < NUM_VECTORS) begin
            j_nxt   = ROW_W'(j_r + 1'b1);
            row_nxt = ROW_W'(j_r + 1'b1);
          end else if (phase_r == PH_PROJ && (i_r + 1'b1) < NUM_VECTORS) begin
            i_nxt     = ROW_W'(i_r + 1'b1);
            row_nxt   = ROW_W'(i_r + 1'b1);
            phase_nxt = PH_NORM1;
          end else begin
            i_nxt     = '0;
            row_nxt   = '0;
            phase_nxt = PH_CLEAN;
          end
        end
      end

      S_DOT: begin
        if (pend_r) begin
          dot_nxt = sneg_r ? dot_r - $signed(prod_r) : dot_r + $signed(prod_r);
        end
        if (k_r < VECTOR_LENGTH) begin
          pend_nxt = 1'b1;
          sneg_nxt = vec_r[kidx][WORD_W-1] ^ u_r[kidx][WORD_W-1];
          k_nxt    = k_r + 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          k_nxt     = '0;
          state_nxt = S_RND;
        end
      end

      S_RND: begin
        c_neg_nxt = dot_r[63];
        c_mag_nxt = c_round[31:0];
        state_nxt = S_SUB;
      end

      S_SUB: begin
        if (pend_r) begin
          vec_nxt[pidx_r] = sneg_r ? vec_r[pidx_r] + $signed(sub_t[WORD_W-1:0])
                                   : vec_r[pidx_r] - $signed(sub_t[WORD_W-1:0]);
        end
        if (k_r < VECTOR_LENGTH) begin
          pend_nxt = 1'b1;
          pidx_nxt = kidx;
          sneg_nxt = c_neg_r ^ u_r[kidx][WORD_W-1];
          k_nxt    = k_r + 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          k_nxt     = '0;
          row_nxt   = j_r;
          state_nxt = S_WR;
        end
      end

      // Cleanup: one component per pass, with the root of the running norm.
      S_CK: begin
        if (k_r == K_W'(VECTOR_LENGTH)) begin
          phase_nxt = PH_FINAL;
          state_nxt = S_NZ;
        end else if (n2_r == 64'd0) begin
          k_nxt = k_r + 1'b1;
        end else begin
          sq_start  = 1'b1;
          state_nxt = S_CSQ;
        end
      end

      S_CSQ: begin
        if (sq_done) begin
          root_nxt  = sq_root;
          h_nxt     = sq_shift;
          state_nxt = S_CM1;
        end
      end

      S_CM1: begin
        state_nxt = S_CM2;
      end

      S_CM2: begin
        if (thr_lhs < prod_r) begin
          state_nxt = S_CM3;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_CK;
        end
      end

      S_CM3: begin
        n2_nxt        = n2_r - prod_r;
        vec_nxt[kidx] = '0;
        k_nxt         = k_r + 1'b1;
        state_nxt     = S_CK;
      end

      S_OUT: begin
        if (k_r < VECTOR_LENGTH) begin
          ostb_nxt  = 1'b1;
          oelem_nxt = degen_r ? '0
                    : (vec_r[kidx][WORD_W-1] ? -$signed(o_mag) : $signed(o_mag));
          odeg_nxt  = degen_r;
          olast_nxt = (i_r == ROW_W'(NUM_VECTORS - 1)) &&
                      (k_r == K_W'(VECTOR_LENGTH - 1));
          k_nxt     = k_r + 1'b1;
        end else begin
          k_nxt = '0;
          if ((i_r + 1'b1) < NUM_VECTORS) begin
            i_nxt     = ROW_W'(i_r + 1'b1);
            row_nxt   = ROW_W'(i_r + 1'b1);
            phase_nxt = PH_CLEAN;
            pend_nxt  = 1'b0;
            state_nxt = S_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_NORM1;
      pend_r  <= 1'b0;
      ostb_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      pend_r  <= pend_nxt;
      ostb_r  <= ostb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    row_r   <= row_nxt;
    k_r     <= k_nxt;
    pidx_r  <= pidx_nxt;
    sneg_r  <= sneg_nxt;
    p_r     <= p_nxt;
    vec_r   <= vec_nxt;
    u_r     <= u_nxt;
    n2_r    <= n2_nxt;
    dot_r   <= dot_nxt;
    c_neg_r <= c_neg_nxt;
    c_mag_r <= c_mag_nxt;
    root_r  <= root_nxt;
    h_r     <= h_nxt;
    degen_r <= degen_nxt;
    oelem_r <= oelem_nxt;
    odeg_r  <= odeg_nxt;
    olast_r <= olast_nxt;
    prod_r  <= mul_a * mul_b;
  end

endmodule

// ----- rtl/core/gram_schmidt_orthonormalizer_unit.sv -----
// Modified Gram-Schmidt orthonormaliser: loading stores one element per accepted start beat.
// After the last element the run time of a full-rank 4x4 set is set by the shared
// square-root unit and the bit-serial divider, which runs once per component; an all-zero
// set uses neither. Results come only after the orthogonalisation pass, in bursts of four.
// busy stays high until the final result.
// Reset (synchronous, active low) clears the load count, queue and sequencers; threshold=2.
module gram_schmidt_orthonormalizer_unit import gso_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [OUT_W-1:0] in_element,
  input  logic                    in_last_in,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [THR_W-1:0]        cfg_zero_threshold,
  output logic                    out_strobe,
  output logic signed [OUT_W-1:0] out_result_element,
  output logic                    out_degenerate,
  output logic                    out_last_out
);

  // The cleanup threshold register accepts a write beat on any cycle.
  logic [THR_W-1:0] zero_threshold_r;

  // Handshake between the front end and the back end through the one-entry queue.
  logic             cmd_valid;
  logic [CNT_W-1:0] cmd_count;
  logic             cmd_ready;
  logic             back_busy;

  // The store is written by the front end while loading and by the back end while
  // running; the two never overlap because loading stops while busy is high.
  ram_wr_t          front_wr, back_wr, ram_wr;
  logic [ADDR_W-1:0] ram_raddr;
  word_t            ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_threshold_r <= THR_W'(2);
    end else if (cfg_valid && cfg_ready) begin
      zero_threshold_r <= cfg_zero_threshold;
    end
  end

  assign ram_wr = front_wr.en ? front_wr : back_wr;

  gso_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_element (in_element),
    .in_last_in (in_last_in),
    .back_busy  (back_busy),
    .cmd_valid  (cmd_valid),
    .cmd_count  (cmd_count),
    .cmd_ready  (cmd_ready),
    .ram_wr     (front_wr)
  );

  // The store holds the loaded set and, during a run, the working vectors.
  gso_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_wr.en),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  gso_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd_valid          (cmd_valid),
    .cmd_count          (cmd_count),
    .cmd_ready          (cmd_ready),
    .back_busy          (back_busy),
    .zero_threshold     (zero_threshold_r),
    .ram_wr             (back_wr),
    .ram_raddr          (ram_raddr),
    .ram_rdata          (ram_rdata),
    .out_strobe         (out_strobe),
    .out_result_element (out_result_element),
    .out_degenerate     (out_degenerate),
    .out_last_out       (out_last_out)
  );

endmodule
